/* rtl/core/urb_pkg.sv */
// Package for the UART ring-buffer service engine.
// Holds the action codes, the register indexes, the reset values and the structs
// shared by the controller, the datapath and the top level. No dependencies.
package urb_pkg;

    // Ring depths used as defaults for the top-level parameters
    localparam int unsigned TX_DEPTH_DEF = 256;
    localparam int unsigned RX_DEPTH_DEF = 256;

    // Register field widths
    localparam int unsigned CAP_W = 9;
    localparam int unsigned LIM_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_TX_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RX_CAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TX_LIM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RX_LIM = 2'd3;

    // Register reset values
    localparam logic [CAP_W-1:0] TX_CAP_RST = 9'd256;
    localparam logic [CAP_W-1:0] RX_CAP_RST = 9'd256;
    localparam logic [LIM_W-1:0] TX_LIM_RST = 8'd60;
    localparam logic [LIM_W-1:0] RX_LIM_RST = 8'd21;

    // Item action codes
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       accept;      // item taken this cycle
        logic       push;        // store byte in transmit ring
        logic       pop;         // read byte from receive ring
        logic       tx_send;     // hand transmit byte to the line
        logic       rx_take;     // store line byte in receive ring
        logic       burst_clear;
        logic       burst_inc;
        logic       load;        // capture the result
        logic [1:0] sched;       // scheduler state for the result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic tx_empty;
        logic tx_one;
        logic tx_full;
        logic rx_empty;
        logic rx_full;
        logic tx_below;   // burst count below transmit limit
        logic tx_last;    // one more byte reaches transmit limit
        logic rx_below;
        logic rx_last;
    } status_t;

    // Result record
    typedef struct packed {
        logic       tx_line_valid;
        logic [7:0] tx_line_byte;
        logic       rx_line_take;
        logic       rx_out_valid;
        logic [7:0] rx_out_byte;
        logic       push_accepted;
        logic [7:0] tx_level;
        logic [7:0] rx_level;
        logic [1:0] service_state;
    } res_t;

endpackage

/* rtl/core/urb_if.sv */
// Channel interfaces of the UART ring-buffer service engine.
// urb_req_if carries input items, urb_rsp_if carries result items. No dependencies.
interface urb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       line_rx_valid;
    logic [7:0] line_rx_byte;
    logic       line_tx_busy;

    modport source (output valid, action, data_byte, line_rx_valid, line_rx_byte,
                    line_tx_busy, input ready);
    modport sink   (input valid, action, data_byte, line_rx_valid, line_rx_byte,
                    line_tx_busy, output ready);
endinterface

interface urb_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_line_valid;
    logic [7:0] tx_line_byte;
    logic       rx_line_take;
    logic       rx_out_valid;
    logic [7:0] rx_out_byte;
    logic       push_accepted;
    logic [7:0] tx_level;
    logic [7:0] rx_level;
    logic [1:0] service_state;

    modport source (output valid, tx_line_valid, tx_line_byte, rx_line_take,
                    rx_out_valid, rx_out_byte, push_accepted, tx_level, rx_level,
                    service_state, input ready);
    modport sink   (input valid, tx_line_valid, tx_line_byte, rx_line_take,
                    rx_out_valid, rx_out_byte, push_accepted, tx_level, rx_level,
                    service_state, output ready);
endinterface

/* rtl/core/urb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module urb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/urb_datapath.sv */
// Datapath of the UART ring-buffer service engine: registers, ring pointers,
// ring stores, burst counter and result register. Depends on urb_pkg and urb_ram.
module urb_datapath #(
    parameter int unsigned TX_DEPTH = urb_pkg::TX_DEPTH_DEF,
    parameter int unsigned RX_DEPTH = urb_pkg::RX_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [urb_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [urb_pkg::CAP_W-1:0]       wr_data,
    input  urb_pkg::cmd_t                   cmd,
    input  logic [7:0]                      data_byte,
    input  logic [7:0]                      line_rx_byte,
    output urb_pkg::status_t                status,
    output urb_pkg::res_t                   res
);

    localparam int unsigned TPW = $clog2(TX_DEPTH);
    localparam int unsigned RPW = $clog2(RX_DEPTH);

    // Clamp a capacity to [2, depth]
    function automatic logic [31:0] clamp_cap(logic [urb_pkg::CAP_W-1:0] c,
                                              logic [31:0] depth);
        logic [31:0] v;
        v = 32'(c);
        if (v < 32'd2)
        begin
            v = 32'd2;
        end
        else if (v > depth)
        begin
            v = depth;
        end
        return v;
    endfunction

    // Bytes held between read and write pointer
    function automatic logic [31:0] ring_level(logic [31:0] w, logic [31:0] r,
                                               logic [31:0] cap);
        if (r <= w)
        begin
            return w - r;
        end
        return cap - (r - w);
    endfunction

    // Advance a pointer with wrap at the capacity
    function automatic logic [31:0] wrap_inc(logic [31:0] p, logic [31:0] cap);
        logic [31:0] n;
        n = p + 32'd1;
        return (n >= cap) ? 32'd0 : n;
    endfunction

    // Saturate a level to one byte
    function automatic logic [7:0] sat8(logic [31:0] v);
        return (v > 32'd255) ? 8'hFF : v[7:0];
    endfunction

    logic [urb_pkg::CAP_W-1:0] tx_cap_reg, rx_cap_reg;
    logic [urb_pkg::LIM_W-1:0] tx_lim_reg, rx_lim_reg;
    logic [TPW-1:0]            tx_wr_ptr_reg, tx_rd_ptr_reg;
    logic [RPW-1:0]            rx_wr_ptr_reg, rx_rd_ptr_reg;
    logic [7:0]                burst_reg;
    logic                      txv_reg, take_reg, popv_reg, acc_reg;
    logic [TPW-1:0]            tx_wr_ptr_next, tx_rd_ptr_next;
    logic [RPW-1:0]            rx_wr_ptr_next, rx_rd_ptr_next;
    logic [7:0]                burst_next;

    logic [31:0] tcap, rcap, tx_lvl, rx_lvl;
    logic [7:0]  tx_lim, rx_lim;
    logic [8:0]  burst_plus;
    logic [7:0]  tx_rdata, rx_rdata;

    // Effective capacities and fill levels
    always_comb
    begin
        tcap   = clamp_cap(tx_cap_reg, TX_DEPTH);
        rcap   = clamp_cap(rx_cap_reg, RX_DEPTH);
        tx_lvl = ring_level(32'(tx_wr_ptr_reg), 32'(tx_rd_ptr_reg), tcap);
        rx_lvl = ring_level(32'(rx_wr_ptr_reg), 32'(rx_rd_ptr_reg), rcap);
    end

    // Burst limits, zero taken as one
    assign tx_lim     = (tx_lim_reg == 8'd0) ? 8'd1 : tx_lim_reg;
    assign rx_lim     = (rx_lim_reg == 8'd0) ? 8'd1 : rx_lim_reg;
    assign burst_plus = {1'b0, burst_reg} + 9'd1;

    // Status to the controller
    always_comb
    begin
        status.tx_empty = (tx_lvl == 32'd0);
        status.tx_one   = (tx_lvl == 32'd1);
        status.tx_full  = (tx_lvl == tcap - 32'd1);
        status.rx_empty = (rx_lvl == 32'd0);
        status.rx_full  = (rx_lvl == rcap - 32'd1);
        status.tx_below = (burst_reg < tx_lim);
        status.tx_last  = (burst_plus >= {1'b0, tx_lim});
        status.rx_below = (burst_reg < rx_lim);
        status.rx_last  = (burst_plus >= {1'b0, rx_lim});
    end

    // Next pointer and burst values
    always_comb
    begin
        tx_wr_ptr_next = tx_wr_ptr_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        burst_next     = burst_reg;
        if (cmd.push)
        begin
            tx_wr_ptr_next = TPW'(wrap_inc(32'(tx_wr_ptr_reg), tcap));
        end
        if (cmd.tx_send)
        begin
            tx_rd_ptr_next = TPW'(wrap_inc(32'(tx_rd_ptr_reg), tcap));
        end
        if (cmd.rx_take)
        begin
            rx_wr_ptr_next = RPW'(wrap_inc(32'(rx_wr_ptr_reg), rcap));
        end
        if (cmd.pop)
        begin
            rx_rd_ptr_next = RPW'(wrap_inc(32'(rx_rd_ptr_reg), rcap));
        end
        if (cmd.burst_clear)
        begin
            burst_next = 8'd0;
        end
        else if (cmd.burst_inc)
        begin
            burst_next = burst_plus[7:0];
        end
        // A capacity write empties its ring
        if (wr_en && wr_index == urb_pkg::REG_TX_CAP)
        begin
            tx_wr_ptr_next = '0;
            tx_rd_ptr_next = '0;
        end
        if (wr_en && wr_index == urb_pkg::REG_RX_CAP)
        begin
            rx_wr_ptr_next = '0;
            rx_rd_ptr_next = '0;
        end
    end

    // Hold registers, pointers and burst count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_cap_reg    <= urb_pkg::TX_CAP_RST;
            rx_cap_reg    <= urb_pkg::RX_CAP_RST;
            tx_lim_reg    <= urb_pkg::TX_LIM_RST;
            rx_lim_reg    <= urb_pkg::RX_LIM_RST;
            tx_wr_ptr_reg <= '0;
            tx_rd_ptr_reg <= '0;
            rx_wr_ptr_reg <= '0;
            rx_rd_ptr_reg <= '0;
            burst_reg     <= 8'd0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    urb_pkg::REG_TX_CAP: tx_cap_reg <= wr_data;
                    urb_pkg::REG_RX_CAP: rx_cap_reg <= wr_data;
                    urb_pkg::REG_TX_LIM: tx_lim_reg <= wr_data[urb_pkg::LIM_W-1:0];
                    urb_pkg::REG_RX_LIM: rx_lim_reg <= wr_data[urb_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            burst_reg     <= burst_next;
        end
    end

    // Transmit ring store
    urb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tx_wr_ptr_reg),
        .wdata (data_byte),
        .raddr (tx_rd_ptr_reg),
        .rdata (tx_rdata)
    );

    // Receive ring store
    urb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (cmd.rx_take),
        .waddr (rx_wr_ptr_reg),
        .wdata (line_rx_byte),
        .raddr (rx_rd_ptr_reg),
        .rdata (rx_rdata)
    );

    // Hold the flags of the accepted item until its read data arrives
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            txv_reg  <= cmd.tx_send;
            take_reg <= cmd.rx_take;
            popv_reg <= cmd.pop;
            acc_reg  <= cmd.push;
        end
    end

    // Capture the result once the ring data is out of the stores
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res.tx_line_valid <= txv_reg;
            res.tx_line_byte  <= txv_reg ? tx_rdata : 8'd0;
            res.rx_line_take  <= take_reg;
            res.rx_out_valid  <= popv_reg;
            res.rx_out_byte   <= popv_reg ? rx_rdata : 8'd0;
            res.push_accepted <= acc_reg;
            res.tx_level      <= sat8(tx_lvl);
            res.rx_level      <= sat8(rx_lvl);
            res.service_state <= cmd.sched;
        end
    end

endmodule

/* rtl/core/urb_ctrl.sv */
// Controller of the UART ring-buffer service engine: item sequencer and the
// idle/transmit/receive scheduler. Depends on urb_pkg.
module urb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       action,
    input  logic             line_rx_valid,
    input  logic             line_tx_busy,
    output logic             out_valid,
    input  logic             out_ready,
    input  urb_pkg::status_t status,
    output urb_pkg::cmd_t    cmd
);

    typedef enum logic {
        SEQ_IDLE,
        SEQ_READ
    } seq_t;

    typedef enum logic [1:0] {
        SCHED_IDLE = 2'd0,
        SCHED_TX   = 2'd1,
        SCHED_RX   = 2'd2
    } sched_t;

    seq_t   seq_reg;
    sched_t sched_reg, sched_next;
    logic   out_valid_reg;
    logic   accept;

    assign in_ready  = (seq_reg == SEQ_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Decode the item into datapath commands and the next scheduler state
    always_comb
    begin
        logic send, take, lvl_zero, cnt_done;
        send       = 1'b0;
        take       = 1'b0;
        lvl_zero   = 1'b0;
        cnt_done   = 1'b0;
        cmd        = '0;
        sched_next = sched_reg;
        cmd.accept = accept;
        cmd.load   = (seq_reg == SEQ_READ);
        cmd.sched  = sched_reg;
        if (accept)
        begin
            case (action)
                urb_pkg::ACT_PUSH: cmd.push = !status.tx_full;
                urb_pkg::ACT_POP:  cmd.pop  = !status.rx_empty;
                urb_pkg::ACT_TICK:
                begin
                    case (sched_reg)
                        SCHED_TX:
                        begin
                            send     = !status.tx_empty && !line_tx_busy && status.tx_below;
                            lvl_zero = status.tx_empty || (send && status.tx_one);
                            cnt_done = send ? status.tx_last : !status.tx_below;
                            cmd.tx_send = send;
                            if (lvl_zero || cnt_done)
                            begin
                                cmd.burst_clear = 1'b1;
                                if (line_rx_valid)
                                begin
                                    sched_next = SCHED_RX;
                                end
                                else if (lvl_zero)
                                begin
                                    sched_next = SCHED_IDLE;
                                end
                            end
                            else
                            begin
                                cmd.burst_inc = send;
                            end
                        end
                        SCHED_RX:
                        begin
                            take = line_rx_valid && status.rx_below && !status.rx_full;
                            cmd.rx_take = take;
                            if (!take || status.rx_last)
                            begin
                                cmd.burst_clear = 1'b1;
                                if (!status.tx_empty)
                                begin
                                    sched_next = SCHED_TX;
                                end
                                else if (!line_rx_valid)
                                begin
                                    sched_next = SCHED_IDLE;
                                end
                            end
                            else
                            begin
                                cmd.burst_inc = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.burst_clear = 1'b1;
                            if (!status.tx_empty)
                            begin
                                sched_next = SCHED_TX;
                            end
                            else if (line_rx_valid)
                            begin
                                sched_next = SCHED_RX;
                            end
                            else
                            begin
                                sched_next = SCHED_IDLE;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Advance the sequencer and scheduler, hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_IDLE;
            sched_reg     <= SCHED_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (seq_reg)
                SEQ_IDLE:
                begin
                    if (accept)
                    begin
                        seq_reg   <= SEQ_READ;
                        sched_reg <= sched_next;
                    end
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                SEQ_READ:
                begin
                    seq_reg       <= SEQ_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    seq_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/uart_ring_buffer_service_engine.sv */
// UART ring-buffer service engine, top level.
// Depends on urb_pkg, urb_if, urb_ram, urb_datapath and urb_ctrl.
//
// Keeps a transmit ring and a receive ring, each backed by a RAM with a
// registered read. An item pushes a transmit byte, pops a receive byte or runs
// one scheduler tick that moves at most one byte between a ring and the line;
// every item gives exactly one result. The accept cycle updates the pointers,
// writes the ring and starts the ring read; the next cycle captures the read
// data and levels into the result register. A new item is taken in the cycle
// the result is taken, but not while the previous item still waits for its
// read data. One slot of each ring stays free; capacities clamp to [2, depth]
// and a capacity write empties its ring. No clearing pass is needed after
// reset.
module uart_ring_buffer_service_engine #(
    parameter int unsigned TX_DEPTH = urb_pkg::TX_DEPTH_DEF,
    parameter int unsigned RX_DEPTH = urb_pkg::RX_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [urb_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [urb_pkg::CAP_W-1:0]     wr_data,
    urb_req_if.sink                       req,
    urb_rsp_if.source                     rsp
);

    urb_pkg::cmd_t    cmd;
    urb_pkg::status_t status;
    urb_pkg::res_t    res;

    // Sequencer and scheduler
    urb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req.valid),
        .in_ready      (req.ready),
        .action        (req.action),
        .line_rx_valid (req.line_rx_valid),
        .line_tx_busy  (req.line_tx_busy),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .status        (status),
        .cmd           (cmd)
    );

    // Rings, registers and result
    urb_datapath #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .cmd          (cmd),
        .data_byte    (req.data_byte),
        .line_rx_byte (req.line_rx_byte),
        .status       (status),
        .res          (res)
    );

    // Drive the result channel
    assign rsp.tx_line_valid = res.tx_line_valid;
    assign rsp.tx_line_byte  = res.tx_line_byte;
    assign rsp.rx_line_take  = res.rx_line_take;
    assign rsp.rx_out_valid  = res.rx_out_valid;
    assign rsp.rx_out_byte   = res.rx_out_byte;
    assign rsp.push_accepted = res.push_accepted;
    assign rsp.tx_level      = res.tx_level;
    assign rsp.rx_level      = res.rx_level;
    assign rsp.service_state = res.service_state;

endmodule
